FILE: src/assert_macros.svh
// Assertion macros shared by the peak bucket RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent true in a cycle -> consequent true in the same cycle
`define WPB_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// antecedent true in a cycle -> consequent true in the next cycle
`define WPB_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/wpb_pkg.sv
// Package for the waveform peak bucket block: widths, payload structs,
// controller states and the command/status structs. No dependencies.
package wpb_pkg;

    localparam int FRAME_W       = 24;   // total_frames, frame position
    localparam int BUCKET_W      = 13;   // bucket_count, bucket counter
    localparam int INDEX_W       = 12;   // reported bucket index
    localparam int SAMPLE_BITS   = 16;
    localparam int LANE_W        = 3;
    localparam int INPUT_LANES   = 4;
    localparam int MAX_CHANNELS  = 4;
    localparam int LANE_LIMIT    = (MAX_CHANNELS < INPUT_LANES) ? MAX_CHANNELS : INPUT_LANES;
    localparam int MAX_RESULTS   = 64;   // results per frame
    localparam int CNT_W         = $clog2(MAX_RESULTS + 1);
    localparam int BUCKET_LIMIT  = 4096;
    localparam int DIV_W         = BUCKET_W + FRAME_W;  // bucket * frames
    localparam int DIV_CNT_W     = $clog2(DIV_W + 1);
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = FRAME_W;
    localparam int FULL_SCALE    = 1 << (SAMPLE_BITS - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TOTAL_FRAMES = 2'd0,
        CFG_BUCKET_COUNT = 2'd1,
        CFG_ACTIVE_CH    = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_ch0;
        logic signed [SAMPLE_BITS-1:0] sample_ch1;
        logic signed [SAMPLE_BITS-1:0] sample_ch2;
        logic signed [SAMPLE_BITS-1:0] sample_ch3;
    } t_wpb_in;

    typedef struct packed {
        logic [INDEX_W-1:0]     bucket_index;
        logic [SAMPLE_BITS-1:0] peak_level;
        logic                   last_of_run;
        logic                   final_bucket;
    } t_wpb_out;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_DIV_T,
        S_WAIT_T,
        S_MUL,
        S_DIV_B,
        S_WAIT_B,
        S_PEAK,
        S_CALC,
        S_TEST
    } t_wpb_state;

    typedef struct packed {
        logic load_cfg;   // latch effective config
        logic div_start;  // launch divider
        logic div_sel;    // 0: frames / buckets, 1: bucket * frames / buckets
        logic take_step;  // keep per-bucket quotient and remainder step
        logic mul;        // register bucket * frames
        logic take_pos;   // keep start quotient and remainder of current bucket
        logic accept;     // input transaction this cycle
        logic peak;       // fold frame into peak
        logic calc;       // compute end of current bucket
        logic advance;    // current bucket closes
        logic push;       // move pending result to output register
        logic push_last;  // pending result is the frame's last one
        logic finish;     // frame bookkeeping, rearm on last frame
    } t_wpb_cmd;

    typedef struct packed {
        logic dirty;      // config written since last setup
        logic div_done;
        logic go;         // current bucket closes within this frame
        logic pend_valid;
        logic out_free;
    } t_wpb_stat;

endpackage

FILE: src/wpb_divider.sv
// Restoring divider, one quotient bit per cycle.
// Depends on wpb_pkg for operand widths.
module wpb_divider
    import wpb_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [DIV_W-1:0]    i_dividend,
    input  logic [BUCKET_W-1:0] i_divisor,
    output logic                o_busy,
    output logic [DIV_W-1:0]    o_quotient,
    output logic [BUCKET_W-1:0] o_remainder
);

    logic                 r_busy;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0]     r_quo;
    logic [BUCKET_W-1:0]  r_rem;
    logic [BUCKET_W-1:0]  r_div;
    logic [BUCKET_W:0]    trial;
    logic                 fits;

    assign trial = {r_rem, r_quo[DIV_W-1]};
    assign fits  = trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= DIV_CNT_W'(DIV_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == DIV_CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_W-2:0], fits};
            // remainder stays below the divisor, so the top bit drops out
            r_rem <= fits ? BUCKET_W'(trial - {1'b0, r_div}) : trial[BUCKET_W-1:0];
        end
    end

    assign o_busy      = r_busy;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

FILE: src/wpb_datapath.sv
// Datapath: config registers, peak fold, incremental bucket boundaries,
// pending result and output register. Depends on wpb_pkg, wpb_divider.
`include "assert_macros.svh"

module wpb_datapath
    import wpb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_wpb_cmd              i_cmd,
    output t_wpb_stat             o_stat,
    input  t_wpb_in               i_data,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_stall,
    output logic                  o_valid,
    output t_wpb_out              o_data
);

    function automatic logic [SAMPLE_BITS-1:0] lane_mag(input logic [SAMPLE_BITS-1:0] x);
        return x[SAMPLE_BITS-1] ? SAMPLE_BITS'(~x + 1'b1) : x;
    endfunction

    // config as written
    logic [FRAME_W-1:0]  r_cfg_t;
    logic [BUCKET_W-1:0] r_cfg_n;
    logic [LANE_W-1:0]   r_cfg_ach;
    logic                r_dirty;

    // effective config
    logic [FRAME_W-1:0]  r_t;
    logic [BUCKET_W-1:0] r_n;
    logic [LANE_W-1:0]   r_lanes;

    logic [FRAME_W-1:0]  r_qstep;
    logic [BUCKET_W-1:0] r_rstep;
    logic [DIV_W-1:0]    r_prod;

    logic [FRAME_W-1:0]  r_sq;
    logic [BUCKET_W-1:0] r_sr;
    logic [FRAME_W-1:0]  r_eq;
    logic [BUCKET_W-1:0] r_er;
    logic [FRAME_W-1:0]  r_e;

    logic [BUCKET_W-1:0]    r_cur;
    logic [FRAME_W-1:0]     r_pos;
    logic [CNT_W-1:0]       r_cnt;
    logic [SAMPLE_BITS-1:0] r_run_peak;
    logic [SAMPLE_BITS-1:0] r_peak;
    t_wpb_in                r_smp;

    logic                r_pend_valid;
    logic [INDEX_W-1:0]  r_pend_idx;
    logic                r_pend_final;

    logic                r_out_valid;
    t_wpb_out            r_out;

    // effective config terms
    logic [FRAME_W-1:0]  t_eff;
    logic [BUCKET_W-1:0] n_base;
    logic [30:0]         n_cap;
    logic [BUCKET_W-1:0] n_eff;
    logic [LANE_W-1:0]   lanes_eff;

    always_comb begin
        t_eff  = (r_cfg_t == '0) ? FRAME_W'(1) : r_cfg_t;
        n_base = (r_cfg_n == '0) ? BUCKET_W'(1) : r_cfg_n;
        if (n_base > BUCKET_W'(BUCKET_LIMIT)) begin
            n_base = BUCKET_W'(BUCKET_LIMIT);
        end
        n_cap = 31'(t_eff) * 31'(MAX_RESULTS);
        n_eff = (31'(n_base) > n_cap) ? n_cap[BUCKET_W-1:0] : n_base;
        if (r_cfg_ach == '0) begin
            lanes_eff = LANE_W'(1);
        end else if (r_cfg_ach > LANE_W'(LANE_LIMIT)) begin
            lanes_eff = LANE_W'(LANE_LIMIT);
        end else begin
            lanes_eff = r_cfg_ach;
        end
    end

    // divider
    logic                div_busy;
    logic [DIV_W-1:0]    div_quo;
    logic [BUCKET_W-1:0] div_rem;

    wpb_divider u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.div_start),
        .i_dividend  (i_cmd.div_sel ? r_prod : DIV_W'(r_t)),
        .i_divisor   (r_n),
        .o_busy      (div_busy),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    // peak over active lanes
    logic [SAMPLE_BITS-1:0] mags [INPUT_LANES];
    logic [SAMPLE_BITS-1:0] peak_new;

    assign mags[0] = lane_mag(r_smp.sample_ch0);
    assign mags[1] = lane_mag(r_smp.sample_ch1);
    assign mags[2] = lane_mag(r_smp.sample_ch2);
    assign mags[3] = lane_mag(r_smp.sample_ch3);

    always_comb begin
        peak_new = r_run_peak;
        for (int i = 0; i < INPUT_LANES; i++) begin
            if (LANE_W'(i) < r_lanes && mags[i] > peak_new) begin
                peak_new = mags[i];
            end
        end
        if (peak_new > SAMPLE_BITS'(FULL_SCALE)) begin
            peak_new = SAMPLE_BITS'(FULL_SCALE);
        end
    end

    // end of current bucket from the running quotient and remainder
    logic [BUCKET_W:0]  rsum;
    logic               carry;
    logic [BUCKET_W-1:0] er_new;
    logic [FRAME_W:0]   eq_new;
    logic [FRAME_W:0]   e_new;
    logic [FRAME_W:0]   next_pos;
    logic               go;

    always_comb begin
        rsum   = {1'b0, r_sr} + {1'b0, r_rstep};
        carry  = rsum >= {1'b0, r_n};
        er_new = carry ? BUCKET_W'(rsum - {1'b0, r_n}) : rsum[BUCKET_W-1:0];
        eq_new = {1'b0, r_sq} + {1'b0, r_qstep} + (FRAME_W+1)'(carry);
        // empty bucket: stretch to one frame
        e_new  = (eq_new == {1'b0, r_sq}) ? ({1'b0, r_sq} + 1'b1) : eq_new;
    end

    assign next_pos = {1'b0, r_pos} + 1'b1;
    assign go = (r_cnt < CNT_W'(MAX_RESULTS)) && (r_cur < r_n)
             && ({1'b0, r_e} <= next_pos);

    // config port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_t   <= FRAME_W'(1);
            r_cfg_n   <= BUCKET_W'(1);
            r_cfg_ach <= LANE_W'(1);
            r_dirty   <= 1'b1;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_TOTAL_FRAMES: r_cfg_t   <= i_cfg_data;
                    CFG_BUCKET_COUNT: r_cfg_n   <= i_cfg_data[BUCKET_W-1:0];
                    CFG_ACTIVE_CH:    r_cfg_ach <= i_cfg_data[LANE_W-1:0];
                    default: ;
                endcase
                r_dirty <= 1'b1;
            end else if (i_cmd.load_cfg) begin
                r_dirty <= 1'b0;
            end
        end
    end

    // setup and boundary payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_cfg) begin
            r_t     <= t_eff;
            r_n     <= n_eff;
            r_lanes <= lanes_eff;
        end
        if (i_cmd.take_step) begin
            r_qstep <= div_quo[FRAME_W-1:0];
            r_rstep <= div_rem;
        end
        if (i_cmd.mul) begin
            r_prod <= DIV_W'(r_cur) * DIV_W'(r_t);
        end
        if (i_cmd.calc) begin
            r_eq <= eq_new[FRAME_W-1:0];
            r_er <= er_new;
            r_e  <= e_new[FRAME_W-1:0];
        end
        if (i_cmd.accept) begin
            r_smp <= i_data;
        end
        if (i_cmd.peak) begin
            r_peak <= peak_new;
        end
        if (i_cmd.advance) begin
            r_pend_idx   <= r_cur[INDEX_W-1:0];
            r_pend_final <= ({1'b0, r_cur} + 1'b1) == {1'b0, r_n};
        end
        if (i_cmd.push) begin
            r_out.bucket_index <= r_pend_idx;
            r_out.peak_level   <= r_peak;
            r_out.last_of_run  <= i_cmd.push_last;
            r_out.final_bucket <= r_pend_final;
        end
    end

    // snippet state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur      <= '0;
            r_pos      <= '0;
            r_cnt      <= '0;
            r_run_peak <= '0;
            r_sq       <= '0;
            r_sr       <= '0;
        end else begin
            if (i_cmd.take_pos) begin
                r_sq <= div_quo[FRAME_W-1:0];
                r_sr <= div_rem;
            end
            if (i_cmd.accept) begin
                r_cnt <= '0;
            end
            if (i_cmd.advance) begin
                r_cur <= r_cur + 1'b1;
                r_sq  <= r_eq;
                r_sr  <= r_er;
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cmd.finish) begin
                if (next_pos >= {1'b0, r_t}) begin
                    // last frame of the snippet: rearm
                    r_run_peak <= '0;
                    r_pos      <= '0;
                    r_cur      <= '0;
                    r_sq       <= '0;
                    r_sr       <= '0;
                end else begin
                    r_run_peak <= (r_cnt != '0) ? '0 : r_peak;
                    r_pos      <= next_pos[FRAME_W-1:0];
                end
            end
        end
    end

    // pending result and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.advance) begin
                r_pend_valid <= 1'b1;
            end else if (i_cmd.push) begin
                r_pend_valid <= 1'b0;
            end
            if (i_cmd.push) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.dirty      = r_dirty;
    assign o_stat.div_done   = !div_busy;
    assign o_stat.go         = go;
    assign o_stat.pend_valid = r_pend_valid;
    assign o_stat.out_free   = !r_out_valid || !i_stall;

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    `WPB_ASSERT_IMP(a_push_free, i_clk, i_rst_n, i_cmd.push, (!r_out_valid || !i_stall), "result overwritten while held")
    `WPB_ASSERT_IMP(a_cnt_cap, i_clk, i_rst_n, 1'b1, (r_cnt <= CNT_W'(MAX_RESULTS)), "too many results for one frame")
    `WPB_ASSERT_IMP(a_adv_range, i_clk, i_rst_n, i_cmd.advance, (r_cur < r_n), "bucket closed past the bucket count")

endmodule

FILE: src/wpb_ctrl.sv
// Controller state machine: setup divisions after config writes, then per
// frame peak, boundary and result sequencing. Depends on wpb_pkg.
module wpb_ctrl
    import wpb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_wpb_stat i_stat,
    output t_wpb_cmd  o_cmd
);

    t_wpb_state r_state;
    t_wpb_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_stat.dirty) begin
                    n_state = S_LOAD;
                end else if (i_valid) begin
                    n_state = S_PEAK;
                end
            end
            S_LOAD:   n_state = S_DIV_T;
            S_DIV_T:  n_state = S_WAIT_T;
            S_WAIT_T: if (i_stat.div_done) n_state = S_MUL;
            S_MUL:    n_state = S_DIV_B;
            S_DIV_B:  n_state = S_WAIT_B;
            S_WAIT_B: if (i_stat.div_done) n_state = S_IDLE;
            S_PEAK:   n_state = S_CALC;
            S_CALC:   n_state = S_TEST;
            S_TEST: begin
                if (!i_stat.pend_valid || i_stat.out_free) begin
                    n_state = i_stat.go ? S_CALC : S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_stall      = i_stat.dirty;
                o_cmd.accept = i_valid && !i_stat.dirty;
            end
            S_LOAD:   o_cmd.load_cfg = 1'b1;
            S_DIV_T:  o_cmd.div_start = 1'b1;
            S_WAIT_T: o_cmd.take_step = i_stat.div_done;
            S_MUL:    o_cmd.mul = 1'b1;
            S_DIV_B: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = 1'b1;
            end
            S_WAIT_B: begin
                o_cmd.div_sel  = 1'b1;
                o_cmd.take_pos = i_stat.div_done;
            end
            S_PEAK:   o_cmd.peak = 1'b1;
            S_CALC:   o_cmd.calc = 1'b1;
            S_TEST: begin
                if (!i_stat.pend_valid || i_stat.out_free) begin
                    o_cmd.push = i_stat.pend_valid;
                    if (i_stat.go) begin
                        o_cmd.advance = 1'b1;
                    end else begin
                        o_cmd.push_last = 1'b1;
                        o_cmd.finish    = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

endmodule

FILE: src/waveform_peak_buckets.sv
// waveform_peak_buckets: peak decimation of a four-lane Q1.15 frame stream.
// A frame is taken in IDLE, then runs PEAK, CALC, TEST; each further result loops CALC/TEST.
// A frame's first result goes pending in TEST and reaches the output register at the next TEST.
// Any config write triggers setup (two 37-step divisions), with frames stalled.
// Reset: synchronous, active low; config returns to 1/1/1 and the same setup runs.
module waveform_peak_buckets
    import wpb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // frame channel
    input  logic                  i_valid,
    output logic                  o_stall,
    input  t_wpb_in               i_data,
    // result channel
    output logic                  o_valid,
    input  logic                  i_stall,
    output t_wpb_out              o_data,
    // config write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Bucket b ends at floor((b+1)*T/N). Instead of dividing per bucket, setup
    // computes T/N (step) and floor(b*T/N) for the current bucket once; each
    // bucket then adds the step and folds the remainder with one compare.

    t_wpb_cmd  cmd;
    t_wpb_stat stat;

    // config registers always take a transaction; a write restarts setup
    assign o_cfg_ready = 1'b1;

    wpb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // One result is held back as pending so that last_of_run is known when
    // it moves to the output register.
    wpb_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_data      (i_data),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_data      (o_data)
    );

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking bench for waveform_peak_buckets: frames in, per-bucket peaks out.
// Depends on wpb_pkg (payload structs, config indexes, widths) and the block itself.
`timescale 1ns / 1ps

module tb_top;
    import wpb_pkg::*;

    localparam int RANDOM_FRAMES  = 92;
    localparam int CFG_SETTLE     = 20;    // frame work still in flight after last result
    localparam int DRAIN_CYCLES   = 40;    // watch for stray results at the end
    localparam int WATCHDOG_LIMIT = 5000;  // cycles with no transaction on any channel

    // index 3 decodes to no register; a write there must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // Behavioral copy of the block: config shadow, open-bucket state, and the
    // queue of bucket reports still owed by the DUT.
    class bucket_peak_model;
        logic [FRAME_W-1:0]  frames_reg;
        logic [BUCKET_W-1:0] buckets_reg;
        logic [LANE_W-1:0]   lanes_reg;
        int unsigned         peak_acc;
        longint unsigned     frame_pos;
        int unsigned         next_bucket;
        t_wpb_out            owed_buckets[$];
        int                  mismatches;

        function new();
            frames_reg  = 1;
            buckets_reg = 1;
            lanes_reg   = 1;
            peak_acc    = 0;
            frame_pos   = 0;
            next_bucket = 0;
            mismatches  = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_TOTAL_FRAMES: frames_reg  = data[FRAME_W-1:0];
                CFG_BUCKET_COUNT: buckets_reg = data[BUCKET_W-1:0];
                CFG_ACTIVE_CH:    lanes_reg   = data[LANE_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned outstanding();
            return owed_buckets.size();
        endfunction

        // Fold one accepted frame in and queue every bucket it closes.
        function void take_frame(t_wpb_in f);
            logic [SAMPLE_BITS-1:0] lane [INPUT_LANES];
            longint unsigned t, n, nxt_frame, b, s, e;
            int unsigned     lanes, peak, mag, cnt;
            int              tail;
            t_wpb_out        r;

            lane = '{f.sample_ch0, f.sample_ch1, f.sample_ch2, f.sample_ch3};
            // zero counts act as one; bucket count saturates twice
            t = (frames_reg == 0) ? 64'd1 : 64'(frames_reg);
            n = (buckets_reg == 0) ? 64'd1 : 64'(buckets_reg);
            if (n > BUCKET_LIMIT) n = 64'(BUCKET_LIMIT);
            if (n > MAX_RESULTS * t) n = MAX_RESULTS * t;
            lanes = (lanes_reg == 0) ? 1 : 32'(lanes_reg);
            if (lanes > LANE_LIMIT) lanes = LANE_LIMIT;

            peak = peak_acc;
            for (int k = 0; k < lanes; k++) begin
                // two's complement magnitude; 0x8000 gives full scale
                mag = lane[k][SAMPLE_BITS-1] ? (32'd1 << SAMPLE_BITS) - 32'(lane[k])
                                             : 32'(lane[k]);
                if (mag > peak) peak = mag;
            end
            if (peak > FULL_SCALE) peak = FULL_SCALE;

            nxt_frame = frame_pos + 1;
            cnt = 0;
            while (cnt < MAX_RESULTS && next_bucket < n) begin
                b = 64'(next_bucket);
                s = (b * t) / n;
                e = ((b + 1) * t) / n;
                if (e <= s) e = s + 1;
                if (e > t) e = t;
                if (e > nxt_frame) break;
                r.bucket_index = next_bucket[INDEX_W-1:0];
                r.peak_level   = peak[SAMPLE_BITS-1:0];
                r.last_of_run  = 1'b0;
                r.final_bucket = (b + 1 == n);
                owed_buckets = {owed_buckets, r};
                next_bucket++;
                cnt++;
            end
            if (cnt > 0) begin
                tail = owed_buckets.size() - 1;
                r = owed_buckets[tail];
                r.last_of_run = 1'b1;
                owed_buckets[tail] = r;
                peak_acc = 0;
            end else begin
                peak_acc = peak;
            end

            // final frame of the snippet (or past it after a shrink): rearm,
            // anything still unreported is dropped
            if (nxt_frame >= t) begin
                peak_acc    = 0;
                frame_pos   = 0;
                next_bucket = 0;
            end else begin
                frame_pos = nxt_frame;
            end
        endfunction

        function void check_bucket(t_wpb_out got);
            t_wpb_out want;
            if (owed_buckets.size() == 0) begin
                $error("bucket_index %0d: result with nothing expected", got.bucket_index);
                mismatches++;
                return;
            end
            want = owed_buckets.pop_front();
            if (got.bucket_index !== want.bucket_index) begin
                $error("bucket_index: expected %0d, got %0d", want.bucket_index,
                       got.bucket_index);
                mismatches++;
            end
            if (got.peak_level !== want.peak_level) begin
                $error("peak_level: expected %0d, got %0d", want.peak_level, got.peak_level);
                mismatches++;
            end
            if (got.last_of_run !== want.last_of_run) begin
                $error("last_of_run: expected %0d, got %0d", want.last_of_run,
                       got.last_of_run);
                mismatches++;
            end
            if (got.final_bucket !== want.final_bucket) begin
                $error("final_bucket: expected %0d, got %0d", want.final_bucket,
                       got.final_bucket);
                mismatches++;
            end
        endfunction
    endclass

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_valid     = 1'b0;
    logic                  o_stall;
    t_wpb_in               i_data      = '0;
    logic                  o_valid;
    logic                  i_stall     = 1'b0;
    t_wpb_out              o_data;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_TOTAL_FRAMES;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    bucket_peak_model model = new();
    bit               quiet = 1'b0;   // phase with no idling on either side
    int unsigned      hold_left = 0;
    int unsigned      idle_cycles = 0;

    waveform_peak_buckets uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Mostly zero or short, now and then long enough to span a whole
    // multi-bucket burst.
    function automatic int unsigned pause_len();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 5) return 0;
        if (r < 9) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Each lane leans toward the extremes (most negative, most positive, zero, -1).
    function automatic t_wpb_in random_frame();
        logic [SAMPLE_BITS-1:0] v [INPUT_LANES];
        for (int k = 0; k < INPUT_LANES; k++) begin
            case ($urandom_range(0, 7))
                0:       v[k] = 16'h8000;
                1:       v[k] = 16'h7FFF;
                2:       v[k] = 16'h0000;
                3:       v[k] = 16'hFFFF;
                default: v[k] = SAMPLE_BITS'($urandom());
            endcase
        end
        return t_wpb_in'({v[0], v[1], v[2], v[3]});
    endfunction

    // Offer one frame and hold it until accepted. Valid is left high so a
    // back-to-back frame needs no second assignment in the same step.
    task automatic send_frame(input t_wpb_in f);
        int unsigned gap;
        gap = quiet ? 0 : pause_len();
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= f;
        do @(posedge i_clk); while (o_stall);
        model.take_frame(f);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        model.set_reg(idx, data);
    endtask

    // Config is only touched with the block idle: every owed bucket reported,
    // then a settling wait for a frame that closed nothing to finish.
    task automatic load_config(input logic [3:0] sel, input logic [CFG_DATA_W-1:0] tf,
                               input logic [CFG_DATA_W-1:0] bc,
                               input logic [CFG_DATA_W-1:0] ac);
        i_valid <= 1'b0;
        do @(posedge i_clk); while (model.outstanding() != 0);
        repeat (CFG_SETTLE) @(posedge i_clk);
        if (sel[0]) write_reg(CFG_TOTAL_FRAMES, tf);
        if (sel[1]) write_reg(CFG_BUCKET_COUNT, bc);
        if (sel[2]) write_reg(CFG_ACTIVE_CH, ac);
        if (sel[3]) write_reg(CFG_UNUSED, CFG_DATA_W'($urandom()));
        i_cfg_valid <= 1'b0;
    endtask

    // Result side backpressure, independent of o_valid.
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else begin
            i_stall   <= !quiet && ($urandom_range(0, 2) == 0);
            hold_left <= pause_len();
        end
    end

    // Compare every result transaction against the oldest owed bucket.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            model.check_bucket(o_data);
        end
    end

    // Progress watchdog: any transaction on any channel resets the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int unsigned           random_left;
        int unsigned           count;
        logic [3:0]            sel;
        logic [CFG_DATA_W-1:0] tf, bc, ac;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset config (1 frame, 1 bucket, 1 lane): each frame is a whole
        // snippet. Lanes 1..3 carry full scale and must be ignored.
        send_frame(t_wpb_in'{16'h8000, 16'h8000, 16'h8000, 16'h8000});
        send_frame(t_wpb_in'{16'h7FFF, 16'h8000, 16'h8000, 16'h8000});
        send_frame(t_wpb_in'{16'h0000, 16'h8000, 16'h8000, 16'h8000});
        send_frame(t_wpb_in'{16'hFFFF, 16'h8000, 16'h8000, 16'h8000});

        // All-zero registers act as one frame, one bucket, one lane.
        load_config(4'b0111, 0, 0, 0);
        send_frame(t_wpb_in'{16'h0001, 16'h8000, 16'h7FFF, 16'h8000});
        send_frame(t_wpb_in'{16'h8001, 16'h0000, 16'h8000, 16'h7FFF});

        // Four lanes, 5 frames into 2 buckets: peak carried across frames.
        load_config(4'b0111, 5, 2, 4);
        send_frame(t_wpb_in'{16'h1234, 16'hFF00, 16'h0000, 16'h0100});
        send_frame(t_wpb_in'{16'h0000, 16'h0000, 16'h0000, 16'h8000});
        send_frame(t_wpb_in'{16'h0010, 16'h7FFF, 16'h0020, 16'h0030});
        send_frame(t_wpb_in'{16'hC000, 16'h0001, 16'h3FFF, 16'hFFFF});
        send_frame(t_wpb_in'{16'h0000, 16'h0000, 16'h0000, 16'h0000});

        // Bucket count far above the limit, lane count above four:
        // one frame gives the full 64 reports.
        load_config(4'b0111, 1, 8191, 7);
        send_frame(random_frame());

        // Bucket count raised mid-snippet: a backlog bigger than one frame
        // may report, the remainder is dropped when the snippet rearms.
        load_config(4'b0111, 3, 3, 2);
        send_frame(random_frame());
        send_frame(random_frame());
        load_config(4'b0010, 0, CFG_DATA_W'(BUCKET_LIMIT), 0);
        send_frame(random_frame());

        // Longest snippet, then shrink to one frame with the position past it.
        load_config(4'b1111, 24'hFFFFFF, CFG_DATA_W'(BUCKET_LIMIT), 3);
        send_frame(random_frame());
        send_frame(random_frame());
        load_config(4'b0001, 1, 0, 0);
        send_frame(random_frame());

        // Random phases: mostly short snippets run to completion, with
        // occasional extreme registers and changes in mid-snippet.
        random_left = RANDOM_FRAMES;
        while (random_left != 0) begin
            quiet = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 4) != 0) begin
                case ($urandom_range(0, 9))
                    0:       tf = 0;
                    1:       tf = 24'hFFFFFF;
                    2:       tf = CFG_DATA_W'($urandom_range(13, 24'hFFFFFF));
                    default: tf = CFG_DATA_W'($urandom_range(1, 12));
                endcase
                case ($urandom_range(0, 9))
                    0:       bc = 0;
                    1:       bc = CFG_DATA_W'($urandom_range(BUCKET_LIMIT, 8191));
                    2:       bc = CFG_DATA_W'($urandom());
                    3:       bc = CFG_DATA_W'(BUCKET_LIMIT);
                    default: bc = CFG_DATA_W'($urandom_range(1, 24));
                endcase
                case ($urandom_range(0, 5))
                    0:       ac = CFG_DATA_W'($urandom());
                    1:       ac = CFG_DATA_W'($urandom_range(0, 7));
                    default: ac = CFG_DATA_W'($urandom_range(1, 4));
                endcase
                sel = 4'($urandom_range(1, 7));
                if ($urandom_range(0, 15) == 0) sel[3] = 1'b1;
                load_config(sel, tf, bc, ac);
            end
            if (model.frames_reg != 0 && model.frames_reg <= 16) begin
                count = $urandom_range(1, 3 * model.frames_reg);
            end else begin
                count = $urandom_range(1, 8);
            end
            if (count > random_left) count = random_left;
            repeat (count) send_frame(random_frame());
            random_left -= count;
        end

        i_valid <= 1'b0;
        while (model.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (model.outstanding() != 0) begin
            $error("%0d expected results never arrived", model.outstanding());
            model.mismatches++;
        end
        if (model.mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
